/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the circle raster core; they
// compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

/* rtl/core/crg_pkg.sv */
// ----------------------------------------------------------------------------
// Circle raster package
// Shared sizes, types, opcodes, register indexes and the per-radius
// distance-squared threshold tables of the circle raster core.
// ----------------------------------------------------------------------------
package crg_pkg;

   // grid and radius limits
   localparam int GRID_SIZE     = 64;
   localparam int MAX_RADIUS    = 63;
   localparam int CFG_DIM_RESET = 64;

   // fixed field widths
   localparam int OPC_W   = 2;
   localparam int COORD_W = 8;
   localparam int RAD_W   = 6;
   localparam int RC_W    = 6;
   localparam int DIM_W   = 7;

   // derived widths
   localparam int IDX_W     = $clog2(GRID_SIZE);
   localparam int RIDX_W    = $clog2(MAX_RADIUS + 1);
   localparam int OFS_W     = RIDX_W + 1;
   localparam int D2_W      = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
   localparam int POS_W     = 10;
   localparam int SPAN_W    = POS_W - 1;

   // distance scaling: tests run on 100x scaled radii
   localparam int SCALE      = 100;
   localparam int SCALE_SQ   = SCALE * SCALE;
   localparam int OUT_INNER  = 65;
   localparam int OUT_OUTER  = 20;

   // configuration port
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = CSR_AW - 2;
   localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = REG_IDX_W'(1);

   typedef enum logic [OPC_W-1:0] {
      OP_OUTLINE = 2'd0,
      OP_FILL    = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_SCAN,
      ST_MEM_RD,
      ST_MEM_WR,
      ST_CELL_RD,
      ST_CELL_WAIT,
      ST_DONE
   } state_type;

   typedef logic [GRID_SIZE-1:0] row_type;
   typedef logic [IDX_W-1:0]     row_addr_type;
   typedef logic [DIM_W-1:0]     dim_type;
   typedef logic [RIDX_W-1:0]    rad_type;
   typedef logic [D2_W-1:0]      d2_type;
   typedef logic [SPAN_W-1:0]    span_type;
   typedef logic signed [OFS_W-1:0] ofs_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef d2_type d2_tbl_type [MAX_RADIUS+1];

   typedef struct packed {
      dim_type grid_width;
      dim_type grid_height;
   } cfg_type;

   typedef struct packed {
      logic         rd_en;
      logic         wr_en;
      row_addr_type addr;
      row_type      wdata;
   } mem_req_type;

   // outline inner bound: smallest d2 with 10000*d2 > (100r-65)^2, or 0 when 100r < 65
   function automatic d2_tbl_type build_outline_min();
      d2_tbl_type t;
      longint     lo;
      for (int r = 0; r <= MAX_RADIUS; r++) begin
         lo = longint'(SCALE) * r - OUT_INNER;
         if (lo < 0) begin
            t[r] = '0;
         end else begin
            t[r] = D2_W'((lo * lo) / SCALE_SQ + 1);
         end
      end
      return t;
   endfunction

   // outline outer bound: largest d2 with 10000*d2 < (100r+20)^2
   function automatic d2_tbl_type build_outline_max();
      d2_tbl_type t;
      longint     hi;
      for (int r = 0; r <= MAX_RADIUS; r++) begin
         hi   = longint'(SCALE) * r + OUT_OUTER;
         t[r] = D2_W'((hi * hi - 1) / SCALE_SQ);
      end
      return t;
   endfunction

   // fill bound and starting square: r*r
   function automatic d2_tbl_type build_radius_sq();
      d2_tbl_type t;
      for (int r = 0; r <= MAX_RADIUS; r++) begin
         t[r] = D2_W'(r * r);
      end
      return t;
   endfunction

   localparam d2_tbl_type OUTLINE_MIN = build_outline_min();
   localparam d2_tbl_type OUTLINE_MAX = build_outline_max();
   localparam d2_tbl_type RADIUS_SQ   = build_radius_sq();

endpackage

/* rtl/core/crg_if.sv */
// ----------------------------------------------------------------------------
// Circle raster channel interfaces
// Valid/ready command and result channels of the circle raster core.
// ----------------------------------------------------------------------------

// command channel
interface crg_req_if import crg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OPC_W-1:0]          opcode;
   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   logic [RAD_W-1:0]          circle_radius;
   logic [RC_W-1:0]           read_col;
   logic [RC_W-1:0]           read_row;

   modport source (
      output valid, opcode, center_x, center_y, circle_radius, read_col, read_row,
      input  ready
   );
   modport sink (
      input  valid, opcode, center_x, center_y, circle_radius, read_col, read_row,
      output ready
   );
endinterface

// result channel
interface crg_rsp_if import crg_pkg::*; ();
   logic valid;
   logic ready;
   logic cell_bit;
   logic done_kind;

   modport source (output valid, cell_bit, done_kind, input ready);
   modport sink   (input valid, cell_bit, done_kind, output ready);
endinterface

/* rtl/core/crg_csr.sv */
// ----------------------------------------------------------------------------
// Circle raster register file
// APB-style configuration registers: grid width and height for clipping.
// ----------------------------------------------------------------------------
module crg_csr import crg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type                cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GRID_WIDTH:  cfg_in.grid_width  = pwdata[DIM_W-1:0];
            REG_GRID_HEIGHT: cfg_in.grid_height = pwdata[DIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_GRID_WIDTH:  prdata = CSR_DW'(cfg_ff.grid_width);
         REG_GRID_HEIGHT: prdata = CSR_DW'(cfg_ff.grid_height);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= DIM_W'(CFG_DIM_RESET);
         cfg_ff.grid_height <= DIM_W'(CFG_DIM_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/crg_grid_mem.sv */
// ----------------------------------------------------------------------------
// Circle raster grid memory
// One row of cells per entry, single port, registered read data. Per-row
// valid flags make unwritten rows read as clear after reset.
// ----------------------------------------------------------------------------
module crg_grid_mem import crg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output row_type     rd_data
);

   row_type              grid_ram [GRID_SIZE];
   logic [GRID_SIZE-1:0] valid_ff, valid_in;
   row_type              rd_row_ff;
   logic                 rd_valid_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         grid_ram[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_row_ff   <= grid_ram[mem_req.addr];
         rd_valid_ff <= valid_ff[mem_req.addr];
      end
   end

   // a row becomes valid on its first write
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_row_ff : '0;

endmodule

/* rtl/core/crg_scan.sv */
// ----------------------------------------------------------------------------
// Circle raster scan engine
// Walks the bounding box one row at a time, one cell per cycle, builds a
// row mask and merges it into the grid memory by read-modify-write. Also
// serves single-cell reads and holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crg_scan import crg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   crg_req_if.sink      req_chan,
   crg_rsp_if.source    rsp_chan,
   output mem_req_type  mem_req,
   input  row_type      mem_rd_data
);

   state_type             state_ff, state_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   rad_type               rad_ff, rad_in;
   d2_type                d2_min_ff, d2_min_in;
   d2_type                d2_max_ff, d2_max_in;
   ofs_type               dx_ff, dx_in, dy_ff, dy_in;
   d2_type                dx2_ff, dx2_in, dy2_ff, dy2_in;
   pos_type               row_pos_ff, row_pos_in, col_pos_ff, col_pos_in;
   row_type               mask_ff, mask_in;
   logic [RC_W-1:0]       rd_col_ff, rd_col_in, rd_row_ff, rd_row_in;
   logic                  res_bit_ff, res_bit_in, res_kind_ff, res_kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_bit_ff, rsp_bit_in, rsp_kind_ff, rsp_kind_in;

   span_type              w_eff, h_eff;
   rad_type               rad_new;
   ofs_type               rad_s;
   d2_type                d2;
   logic                  cell_hit, row_last, col_last;

   function automatic span_type clip_dim(dim_type v);
      if (int'(v) > GRID_SIZE) begin
         return SPAN_W'(GRID_SIZE);
      end
      return SPAN_W'(v);
   endfunction

   function automatic logic in_range(pos_type p, span_type lim);
      return !p[POS_W-1] && (p[POS_W-2:0] < lim);
   endfunction

   assign w_eff   = clip_dim(cfg.grid_width);
   assign h_eff   = clip_dim(cfg.grid_height);
   assign rad_new = (int'(req_chan.circle_radius) > MAX_RADIUS) ? RIDX_W'(MAX_RADIUS)
                                                                 : RIDX_W'(req_chan.circle_radius);
   assign rad_s   = $signed({1'b0, rad_ff});
   assign row_last = (dy_ff == rad_s);
   assign col_last = (dx_ff == rad_s);

   // per-cell distance test against the command's d2 window, clipped to the grid width
   assign d2       = dx2_ff + dy2_ff;
   assign cell_hit = (d2 >= d2_min_ff) && (d2 <= d2_max_ff) && in_range(col_pos_ff, w_eff);

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.cell_bit  = rsp_bit_ff;
   assign rsp_chan.done_kind = rsp_kind_ff;

   // sequencer: next state, datapath updates, memory requests
   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      rad_in       = rad_ff;
      d2_min_in    = d2_min_ff;
      d2_max_in    = d2_max_ff;
      dx_in        = dx_ff;
      dx2_in       = dx2_ff;
      dy_in        = dy_ff;
      dy2_in       = dy2_ff;
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      mask_in      = mask_ff;
      rd_col_in    = rd_col_ff;
      rd_row_in    = rd_row_ff;
      res_bit_in   = res_bit_ff;
      res_kind_in  = res_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bit_in   = rsp_bit_ff;
      rsp_kind_in  = rsp_kind_ff;

      mem_req.rd_en = 1'b0;
      mem_req.wr_en = 1'b0;
      mem_req.addr  = row_pos_ff[IDX_W-1:0];
      mem_req.wdata = mem_rd_data | mask_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cx_in       = req_chan.center_x;
               rad_in      = rad_new;
               rd_col_in   = req_chan.read_col;
               rd_row_in   = req_chan.read_row;
               res_bit_in  = 1'b0;
               res_kind_in = 1'b0;
               dy_in       = OFS_W'(0) - OFS_W'(rad_new);
               dy2_in      = RADIUS_SQ[rad_new];
               row_pos_in  = POS_W'(req_chan.center_y) - POS_W'(rad_new);
               unique case (opcode_type'(req_chan.opcode))
                  OP_OUTLINE: begin
                     d2_min_in = OUTLINE_MIN[rad_new];
                     d2_max_in = OUTLINE_MAX[rad_new];
                     state_in  = ST_ROW;
                  end
                  OP_FILL: begin
                     d2_min_in = '0;
                     d2_max_in = RADIUS_SQ[rad_new];
                     state_in  = ST_ROW;
                  end
                  OP_READ: begin
                     state_in = ST_CELL_RD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // start a row, or skip it when it is clipped
         ST_ROW: begin
            if (in_range(row_pos_ff, h_eff)) begin
               dx_in      = OFS_W'(0) - OFS_W'(rad_ff);
               dx2_in     = RADIUS_SQ[rad_ff];
               col_pos_in = POS_W'(cx_ff) - POS_W'(rad_ff);
               mask_in    = '0;
               state_in   = ST_SCAN;
            end else if (row_last) begin
               state_in = ST_DONE;
            end else begin
               dy_in      = dy_ff + OFS_W'(1);
               dy2_in     = dy2_ff + D2_W'($signed({dy_ff, 1'b1}));
               row_pos_in = row_pos_ff + POS_W'(1);
            end
         end

         // one cell per cycle into the row mask
         ST_SCAN: begin
            if (cell_hit) begin
               mask_in[col_pos_ff[IDX_W-1:0]] = 1'b1;
            end
            if (col_last) begin
               state_in = ST_MEM_RD;
            end else begin
               dx_in      = dx_ff + OFS_W'(1);
               dx2_in     = dx2_ff + D2_W'($signed({dx_ff, 1'b1}));
               col_pos_in = col_pos_ff + POS_W'(1);
            end
         end

         ST_MEM_RD: begin
            mem_req.rd_en = 1'b1;
            state_in      = ST_MEM_WR;
         end

         // merge mask into the row just read
         ST_MEM_WR: begin
            mem_req.wr_en = 1'b1;
            if (row_last) begin
               state_in = ST_DONE;
            end else begin
               dy_in      = dy_ff + OFS_W'(1);
               dy2_in     = dy2_ff + D2_W'($signed({dy_ff, 1'b1}));
               row_pos_in = row_pos_ff + POS_W'(1);
               state_in   = ST_ROW;
            end
         end

         ST_CELL_RD: begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = IDX_W'(rd_row_ff);
            state_in      = ST_CELL_WAIT;
         end

         ST_CELL_WAIT: begin
            res_kind_in = 1'b1;
            res_bit_in  = (SPAN_W'(rd_col_ff) < w_eff) && (SPAN_W'(rd_row_ff) < h_eff) &&
                          mem_rd_data[IDX_W'(rd_col_ff)];
            state_in    = ST_DONE;
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = res_bit_ff;
               rsp_kind_in  = res_kind_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      rad_ff      <= rad_in;
      d2_min_ff   <= d2_min_in;
      d2_max_ff   <= d2_max_in;
      dx_ff       <= dx_in;
      dx2_ff      <= dx2_in;
      dy_ff       <= dy_in;
      dy2_ff      <= dy2_in;
      row_pos_ff  <= row_pos_in;
      col_pos_ff  <= col_pos_in;
      mask_ff     <= mask_in;
      rd_col_ff   <= rd_col_in;
      rd_row_ff   <= rd_row_in;
      res_bit_ff  <= res_bit_in;
      res_kind_ff <= res_kind_in;
      rsp_bit_ff  <= rsp_bit_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   // checks
   `ASSERT_NEVER(a_mem_rd_wr_excl, clock, reset, mem_req.rd_en && mem_req.wr_en, "grid memory read and write in one cycle")
   `ASSERT_PROP(a_wr_after_rd, clock, reset, mem_req.wr_en |-> ($past(mem_req.rd_en) && (mem_req.addr == $past(mem_req.addr))), "row write without read of same row")
   `ASSERT_PROP(a_dx2_square, clock, reset, (state_ff == ST_SCAN) |-> (int'(dx2_ff) == int'(dx_ff) * int'(dx_ff)), "running dx square out of step")
   `ASSERT_PROP(a_rsp_from_done, clock, reset, $rose(rsp_chan.valid) |-> $past(state_ff == ST_DONE), "result raised outside done state")

endmodule

/* rtl/core/circle_raster_into_grid_core.sv */
// A read passes ST_CELL_RD (row read), ST_CELL_WAIT (bit pick) and ST_DONE (result).
// Draw and fill scan the bounding box one cell per cycle: each row inside the grid
// goes through setup, its 2r+1 cells, row read and row write; a clipped row only
// passes the setup state ST_ROW before the next row is taken.
// One command is in flight at a time; a new one is taken while a result waits.
// Reset (synchronous): grid reads as clear via per-row valid flags, no clearing pass.
// ----------------------------------------------------------------------------
// Circle raster core
// Top level: configuration registers, grid row memory and scan engine.
// ----------------------------------------------------------------------------
module circle_raster_into_grid_core import crg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   crg_req_if.sink           req_chan,
   crg_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type     cfg;
   mem_req_type mem_req;
   row_type     mem_rd_data;

   crg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   crg_grid_mem u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   crg_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

endmodule
